@@ sv/isoc_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU stillness offset calibrator: shared types and constants
// Sample layout, accumulator widths, divider constants, register map
// and calibration phase codes.
// ----------------------------------------------------------------------------
package isoc_pkg;

   localparam int AXIS_W    = 16;
   localparam int NUM_AXES  = 6;
   localparam int NUM_GYRO  = 3;
   localparam int GYRO_BASE = 3;
   localparam int AXIS_AZ   = 2;

   localparam int SUM_W = 25;
   localparam int MAG_W = 24;

   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 31;
   localparam int DIV_W       = 8;
   localparam int DIV_LAT     = 4;

   localparam int THR_W     = 16;
   localparam int NEEDED_W  = 8;
   localparam int GRAVITY_W = 15;

   localparam logic [THR_W-1:0]     THRESHOLD_RST = 16'd10;
   localparam logic [NEEDED_W-1:0]  NEEDED_RST    = 8'd30;
   localparam logic [GRAVITY_W-1:0] GRAVITY_RST   = 15'd16383;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_NEEDED    = 2'd1,
      CSR_GRAVITY   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_AVG  = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef logic [NUM_AXES-1:0][AXIS_W-1:0] sample_type;

endpackage

@@ sv/isoc_div.sv @@
// ----------------------------------------------------------------------------
// Offset divider
// Divides one signed axis sum by a constant count, truncating toward zero,
// through reciprocal multiply and a single correction step over four stages.
// ----------------------------------------------------------------------------
module isoc_div import isoc_pkg::*; #(
   parameter int DIVISOR = 255
) (
   input  logic                    clock,
   input  logic                    advance,
   input  logic signed [SUM_W-1:0] sum_i,
   output logic [AXIS_W-1:0]       offset_o
);

   localparam int PROD_W = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
   localparam logic [DIV_W-1:0] DIV_N = DIV_W'(DIVISOR);

   logic [SUM_W-1:0]  abs_in;
   logic              neg_a_ff;
   logic [MAG_W-1:0]  mag_a_ff;

   logic [PROD_W-1:0] prod;
   logic              neg_b_ff;
   logic [MAG_W-1:0]  mag_b_ff;
   logic [MAG_W-1:0]  q_b_ff;

   logic [MAG_W+DIV_W-1:0] qn_full;
   logic              neg_c_ff;
   logic [MAG_W-1:0]  mag_c_ff;
   logic [MAG_W-1:0]  q_c_ff;
   logic [MAG_W-1:0]  qn_c_ff;

   logic [MAG_W-1:0]  rem;
   logic [MAG_W-1:0]  q_fix;
   logic [AXIS_W-1:0] off_in;
   logic [AXIS_W-1:0] off_d_ff;

   assign abs_in  = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
   assign prod    = {{RECIP_W{1'b0}}, mag_a_ff} * {{MAG_W{1'b0}}, RECIP};
   assign qn_full = {{DIV_W{1'b0}}, q_b_ff} * {{MAG_W{1'b0}}, DIV_N};
   assign rem     = mag_c_ff - qn_c_ff;
   assign q_fix   = (rem >= MAG_W'(DIV_N)) ? q_c_ff + MAG_W'(1) : q_c_ff;
   assign off_in  = neg_c_ff ? AXIS_W'(-q_fix[AXIS_W-1:0]) : q_fix[AXIS_W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_a_ff <= sum_i[SUM_W-1];
         mag_a_ff <= abs_in[MAG_W-1:0];
         neg_b_ff <= neg_a_ff;
         mag_b_ff <= mag_a_ff;
         q_b_ff   <= prod[RECIP_SHIFT +: MAG_W];
         neg_c_ff <= neg_b_ff;
         mag_c_ff <= mag_b_ff;
         q_c_ff   <= q_b_ff;
         qn_c_ff  <= qn_full[MAG_W-1:0];
         off_d_ff <= off_in;
      end
   end

   assign offset_o = off_d_ff;

endmodule

@@ sv/imu_stillness_offset_calibrator_core.sv @@
// ----------------------------------------------------------------------------
// IMU stillness offset calibrator
// Waits for gyro stillness, averages a run of six-axis samples into
// per-axis offsets and, once calibrated, subtracts them from every sample.
// ----------------------------------------------------------------------------
// Each request passes through p1, p2, the carry stages and the result register.
// Throughput: one request per cycle; the whole pipeline holds while a
// result waits on rsp_tready.
// Offsets come from a four-stage reciprocal divider running beside the data.
// Reset clears the pipeline and calibration state and loads register defaults.
module imu_stillness_offset_calibrator_core import isoc_pkg::*; #(
   parameter int AVG_SAMPLES = 255
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
   input  logic [NUM_AXES*AXIS_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // accel_x_corr, accel_y_corr, accel_z_corr, gyro_x_corr, gyro_y_corr, gyro_z_corr
   output logic [NUM_AXES*AXIS_W-1:0] rsp_tdata,
   // cal_phase
   output logic [1:0]               rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_AW-1:0]        csr_paddr,
   input  logic [CSR_DW-1:0]        csr_pwdata,
   output logic [CSR_DW-1:0]        csr_prdata,
   output logic                     csr_pready
);

   localparam int CNT_W = $clog2(AVG_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(AVG_SAMPLES);

   logic                  advance;
   logic                  step;
   logic                  csr_wr;
   csr_index_type         csr_idx;

   logic [THR_W-1:0]      threshold_ff;
   logic [NEEDED_W-1:0]   needed_ff;
   logic [GRAVITY_W-1:0]  gravity_ff;

   phase_type             phase_ff, phase_in;
   logic [NEEDED_W-1:0]   still_left_ff, still_left_in;
   logic                  have_prev_ff;
   logic [NUM_GYRO-1:0][AXIS_W-1:0] prev_gyro_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic signed [NUM_AXES-1:0][SUM_W-1:0] sums_ff, sums_in;

   logic                  p1_valid_ff;
   sample_type            p1_sample_ff;
   logic                  p2_valid_ff;
   sample_type            p2_sample_ff;
   phase_type             p2_phase_ff;

   logic                  car_valid_ff  [DIV_LAT];
   sample_type            car_sample_ff [DIV_LAT];
   phase_type             car_phase_ff  [DIV_LAT];

   logic [NUM_AXES-1:0][AXIS_W-1:0] div_off;
   sample_type            rsp_data_in;
   logic                  rsp_valid_ff;
   sample_type            rsp_data_ff;
   phase_type             rsp_user_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign step       = advance && p1_valid_ff;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         CSR_THRESHOLD: csr_prdata = CSR_DW'(threshold_ff);
         CSR_NEEDED:    csr_prdata = CSR_DW'(needed_ff);
         CSR_GRAVITY:   csr_prdata = CSR_DW'(gravity_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      logic                     still;
      logic signed [AXIS_W:0]   diff;
      logic [AXIS_W:0]          mag;
      logic signed [SUM_W-1:0]  v;
      phase_in      = phase_ff;
      still_left_in = still_left_ff;
      count_in      = count_ff;
      sums_in       = sums_ff;
      still         = have_prev_ff;
      diff          = '0;
      mag           = '0;
      v             = '0;
      case (phase_ff)
         PH_WAIT: begin
            for (int g = 0; g < NUM_GYRO; g++) begin
               diff = $signed({p1_sample_ff[GYRO_BASE+g][AXIS_W-1], p1_sample_ff[GYRO_BASE+g]})
                    - $signed({prev_gyro_ff[g][AXIS_W-1], prev_gyro_ff[g]});
               mag  = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : (AXIS_W+1)'(diff);
               if (mag > {1'b0, threshold_ff}) begin
                  still = 1'b0;
               end
            end
            if (still && still_left_ff != '0) begin
               still_left_in = still_left_ff - NEEDED_W'(1);
            end
            if (still_left_in == '0) begin
               phase_in = PH_AVG;
            end
         end
         PH_AVG: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               v = SUM_W'($signed(p1_sample_ff[i]));
               if (i == AXIS_AZ) begin
                  v = v - $signed(SUM_W'(gravity_ff));
               end
               sums_in[i] = sums_ff[i] + v;
            end
            count_in = count_ff + CNT_W'(1);
            if (count_in >= CNT_END) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RST;
         needed_ff     <= NEEDED_RST;
         gravity_ff    <= GRAVITY_RST;
         phase_ff      <= PH_WAIT;
         still_left_ff <= NEEDED_RST;
         have_prev_ff  <= 1'b0;
         count_ff      <= '0;
         sums_ff       <= '0;
      end else begin
         if (step) begin
            phase_ff      <= phase_in;
            still_left_ff <= still_left_in;
            count_ff      <= count_in;
            sums_ff       <= sums_in;
            if (phase_ff == PH_WAIT) begin
               have_prev_ff <= 1'b1;
            end
         end
         if (csr_wr) begin
            case (csr_idx)
               CSR_THRESHOLD: threshold_ff <= csr_pwdata[THR_W-1:0];
               CSR_NEEDED: begin
                  needed_ff <= csr_pwdata[NEEDED_W-1:0];
                  if (phase_ff == PH_WAIT) begin
                     still_left_ff <= csr_pwdata[NEEDED_W-1:0];
                  end
               end
               CSR_GRAVITY:   gravity_ff <= csr_pwdata[GRAVITY_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && phase_ff == PH_WAIT) begin
         for (int g = 0; g < NUM_GYRO; g++) begin
            prev_gyro_ff[g] <= p1_sample_ff[GYRO_BASE+g];
         end
      end
   end

   genvar ax;
   generate
      for (ax = 0; ax < NUM_AXES; ax++) begin : g_div
         isoc_div #(
            .DIVISOR (AVG_SAMPLES)
         ) u_div (
            .clock    (clock),
            .advance  (advance),
            .sum_i    (sums_ff[ax]),
            .offset_o (div_off[ax])
         );
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (car_phase_ff[DIV_LAT-1] == PH_DONE) begin
            rsp_data_in[i] = car_sample_ff[DIV_LAT-1][i] - div_off[i];
         end else begin
            rsp_data_in[i] = car_sample_ff[DIV_LAT-1][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            car_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         p1_valid_ff     <= req_tvalid;
         p2_valid_ff     <= p1_valid_ff;
         car_valid_ff[0] <= p2_valid_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            car_valid_ff[k] <= car_valid_ff[k-1];
         end
         rsp_valid_ff    <= car_valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_sample_ff     <= req_tdata;
         p2_sample_ff     <= p1_sample_ff;
         p2_phase_ff      <= phase_in;
         car_sample_ff[0] <= p2_sample_ff;
         car_phase_ff[0]  <= p2_phase_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            car_sample_ff[k] <= car_sample_ff[k-1];
            car_phase_ff[k]  <= car_phase_ff[k-1];
         end
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= car_phase_ff[DIV_LAT-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ sv/isoc_checker.sv @@
// ----------------------------------------------------------------------------
// IMU stillness offset calibrator: port checker
// Watches the result channel for phase ordering, stall behavior and reset.
// ----------------------------------------------------------------------------
module isoc_checker import isoc_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [NUM_AXES*AXIS_W-1:0] rsp_tdata,
   input logic [1:0]                 rsp_tuser
);

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == PH_DONE |=> !rsp_tvalid || rsp_tuser == PH_DONE)
      else $error("calibrated phase left");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == PH_AVG |=> !rsp_tvalid || rsp_tuser != PH_WAIT)
      else $error("phase went back to waiting");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= PH_DONE)
      else $error("unused phase code on result");

endmodule

bind imu_stillness_offset_calibrator_core isoc_checker u_isoc_checker (.*);
